// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C EEPROM master
// Bus phase codes, the tick word layout, the result word layout and the
// register indexes of the control port.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_S_HI   = 5'd1,
      PH_S_FALL = 5'd2,
      PH_S_LO   = 5'd3,
      PH_DEV_LO = 5'd4,
      PH_DEV_HI = 5'd5,
      PH_AH_LO  = 5'd6,
      PH_AH_HI  = 5'd7,
      PH_AL_LO  = 5'd8,
      PH_AL_HI  = 5'd9,
      PH_R_HI   = 5'd10,
      PH_R_FALL = 5'd11,
      PH_R_LO   = 5'd12,
      PH_RD_LO  = 5'd13,
      PH_RD_HI  = 5'd14,
      PH_DAT_LO = 5'd15,
      PH_DAT_HI = 5'd16,
      PH_RX_LO  = 5'd17,
      PH_RX_HI  = 5'd18,
      PH_P_LO   = 5'd19,
      PH_P_HI   = 5'd20,
      PH_P_END  = 5'd21
   } phase_type;

   // control port register indexes
   localparam logic CSR_DEVICE_BYTE = 1'b0;
   localparam logic CSR_PHASE_TICKS = 1'b1;

   localparam logic [7:0] DEVICE_BYTE_RESET = 8'hA0;
   localparam logic [7:0] PHASE_TICKS_RESET = 8'd4;
   localparam logic [6:0] ADDR_HI_MASK      = 7'h7F;
   localparam logic [7:0] READ_BIT          = 8'h01;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   // one bus tick
   typedef struct packed {
      logic        req_valid;
      logic        func;
      logic [14:0] mem_addr;
      logic [15:0] byte_count;
      logic [7:0]  wr_byte;
      logic        sda_in;
   } item_type;

   // pin levels and strobes after one tick
   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       write_protect;
      logic       busy_res;
      logic       wr_byte_req;
      logic [7:0] rd_byte;
      logic       rd_valid;
      logic       rd_last;
   } result_type;

   typedef struct packed {
      logic [7:0] device_byte;
      logic [7:0] phase_ticks;
   } csr_type;

endpackage

// ===== hdl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq: bus phase sequencer
// Holds the transaction state and advances it by one tick per accepted word.
// ----------------------------------------------------------------------------
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  csr_type    csr,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  timer_ff, timer_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] left_ff, left_in;
   logic [14:0] addr_ff, addr_in;
   logic        wr_ff, wr_in;

   logic [7:0]  ticks;
   logic [3:0]  bit_next;
   logic [7:0]  rx_shift;
   logic [15:0] left_dec;
   logic        wreq, rvalid, rlast;
   logic [7:0]  rbyte;

   assign ticks    = (csr.phase_ticks == 8'd0) ? 8'd1 : csr.phase_ticks;
   assign bit_next = bit_ff + 4'd1;
   assign rx_shift = {shift_ff[6:0], item.sda_in};
   assign left_dec = left_ff - 16'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      wr_in    = wr_ff;
      wreq     = 1'b0;
      rvalid   = 1'b0;
      rlast    = 1'b0;
      rbyte    = 8'd0;
      if (phase_ff == PH_IDLE) begin
         if (item.req_valid) begin
            wr_in    = item.func;
            addr_in  = item.mem_addr;
            left_in  = item.byte_count;
            phase_in = PH_S_HI;
            timer_in = 8'd0;
            bit_in   = 4'd0;
            shift_in = 8'd0;
         end
      end else if (({1'b0, timer_ff} + 9'd1) < {1'b0, ticks}) begin
         timer_in = timer_ff + 8'd1;
      end else begin
         timer_in = 8'd0;
         case (phase_ff)
            PH_S_HI:   phase_in = PH_S_FALL;
            PH_S_FALL: phase_in = PH_S_LO;
            PH_S_LO: begin
               phase_in = PH_DEV_LO;
               bit_in   = 4'd0;
               shift_in = csr.device_byte;
            end
            PH_R_HI:   phase_in = PH_R_FALL;
            PH_R_FALL: phase_in = PH_R_LO;
            PH_R_LO: begin
               phase_in = PH_RD_LO;
               bit_in   = 4'd0;
               shift_in = csr.device_byte | READ_BIT;
            end
            PH_P_LO:  phase_in = PH_P_HI;
            PH_P_HI:  phase_in = PH_P_END;
            PH_P_END: phase_in = PH_IDLE;
            PH_DEV_LO, PH_AH_LO, PH_AL_LO, PH_RD_LO, PH_DAT_LO, PH_RX_LO: begin
               phase_in = phase_type'(phase_ff + 5'd1);
            end
            PH_RX_HI: begin
               if (bit_ff < BITS_PER_BYTE) begin
                  shift_in = rx_shift;
                  bit_in   = bit_next;
                  phase_in = PH_RX_LO;
                  if (bit_next == BITS_PER_BYTE) begin
                     left_in = left_dec;
                     rvalid  = 1'b1;
                     rbyte   = rx_shift;
                     rlast   = (left_dec == 16'd0);
                  end
               end else begin
                  phase_in = (left_ff != 16'd0) ? PH_RX_LO : PH_P_LO;
                  bit_in   = 4'd0;
                  shift_in = 8'd0;
               end
            end
            default: begin
               // transmit high-clock phases
               if (bit_ff < BITS_PER_BYTE) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_next;
                  phase_in = phase_type'(phase_ff - 5'd1);
               end else begin
                  bit_in   = 4'd0;
                  shift_in = 8'd0;
                  if (phase_ff == PH_DEV_HI) begin
                     phase_in = PH_AH_LO;
                     shift_in = {1'b0, addr_ff[14:8] & ADDR_HI_MASK};
                  end else if (phase_ff == PH_AH_HI) begin
                     phase_in = PH_AL_LO;
                     shift_in = addr_ff[7:0];
                  end else if (phase_ff == PH_AL_HI && !wr_ff) begin
                     phase_in = PH_R_HI;
                  end else if (phase_ff == PH_RD_HI) begin
                     phase_in = (left_ff != 16'd0) ? PH_RX_LO : PH_P_LO;
                  end else if ((phase_ff == PH_AL_HI || phase_ff == PH_DAT_HI)
                               && left_ff != 16'd0) begin
                     wreq     = 1'b1;
                     left_in  = left_dec;
                     phase_in = PH_DAT_LO;
                     shift_in = item.wr_byte;
                  end else begin
                     phase_in = PH_P_LO;
                  end
               end
            end
         endcase
      end
   end

   // pin levels from the state just entered
   always_comb begin
      result               = '0;
      result.wr_byte_req   = wreq;
      result.rd_byte       = rbyte;
      result.rd_valid      = rvalid;
      result.rd_last       = rlast;
      result.busy_res      = (phase_in != PH_IDLE);
      result.write_protect = !((phase_in != PH_IDLE) && wr_in);
      case (phase_in)
         PH_IDLE, PH_S_HI, PH_R_HI, PH_P_END: begin
            result.scl         = 1'b1;
            result.sda_release = 1'b1;
         end
         PH_S_FALL, PH_R_FALL, PH_P_HI: begin
            result.scl         = 1'b1;
            result.sda_release = 1'b0;
         end
         PH_S_LO, PH_R_LO, PH_P_LO: begin
            result.scl         = 1'b0;
            result.sda_release = 1'b0;
         end
         PH_RX_LO, PH_RX_HI: begin
            // release for data bits, then ack all but the last byte
            result.scl         = (phase_in == PH_RX_HI);
            result.sda_release = (bit_in < BITS_PER_BYTE) ? 1'b1 : (left_in == 16'd0);
         end
         default: begin
            result.scl         = phase_in[0];
            result.sda_release = (bit_in < BITS_PER_BYTE) ? shift_in[7] : 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= 8'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         left_ff  <= 16'd0;
         addr_ff  <= 15'd0;
         wr_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         wr_ff    <= wr_in;
      end
   end

endmodule

// ===== hdl/i2cm_out_reg.sv =====
// ----------------------------------------------------------------------------
// i2cm_out_reg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cm_out_reg
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       take,
   output logic       valid,
   output result_type held
);

   logic       valid_ff, valid_in;
   result_type held_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

   assign valid = valid_ff;
   assign held  = held_ff;

endmodule

// ===== hdl/i2c_eeprom_master.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_master: tick-driven I2C master for a two-address-byte EEPROM
// Output: the result word of a tick is valid in the cycle after it is accepted.
// Throughput: one tick word per cycle while the result register is empty or
//   being drained in the same cycle; a full, undrained register stalls input.
// Reset: synchronous, active high; bus idle, registers back to device byte
//   0xA0 and four ticks per phase, result register empty.
// ----------------------------------------------------------------------------
module i2c_eeprom_master
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tick words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // req_valid, mem_addr[14:0], byte_count[15:0],
                                   // wr_byte[7:0], sda_in, zero fill
   input  logic        req_tuser,  // func
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // scl, sda_release, write_protect, busy_res,
                                   // wr_byte_req, rd_byte[7:0], rd_valid, zero fill
   output logic        rsp_tlast,  // rd_last
   // control registers
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   csr_type    csr_ff;
   item_type   item;
   result_type step_result;
   result_type held;
   logic       accept;
   logic       out_valid;

   // unpack the tick word, lowest field first
   assign item.req_valid  = req_tdata[0];
   assign item.func       = req_tuser;
   assign item.mem_addr   = req_tdata[15:1];
   assign item.byte_count = req_tdata[31:16];
   assign item.wr_byte    = req_tdata[39:32];
   assign item.sda_in     = req_tdata[40];

   // take a new word when the result slot is empty or drains now
   assign req_tready = ~out_valid | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // control registers; the user must write them only while the bus is quiet, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.device_byte <= DEVICE_BYTE_RESET;
         csr_ff.phase_ticks <= PHASE_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEVICE_BYTE: csr_ff.device_byte <= csr_wdata;
            CSR_PHASE_TICKS: csr_ff.phase_ticks <= csr_wdata;
            default:         csr_ff <= csr_ff;
         endcase
      end
   end

   // advance the bus sequencer by one tick per accepted word
   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .item    (item),
      .csr     (csr_ff),
      .result  (step_result)
   );

   // hold the pin levels of that tick until taken
   i2cm_out_reg u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .result (step_result),
      .take   (rsp_tready),
      .valid  (out_valid),
      .held   (held)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {2'b00, held.rd_valid, held.rd_byte, held.wr_byte_req,
                        held.busy_res, held.write_protect, held.sda_release, held.scl};
   assign rsp_tlast  = held.rd_last;

   // a last-byte flag comes only with a received byte
   a_last_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && held.rd_last |-> held.rd_valid)
      else $error("rd_last without rd_valid");

   // a tick never both fetches a write byte and delivers a read byte
   a_no_rd_and_wr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(held.rd_valid && held.wr_byte_req))
      else $error("read and write strobes in one tick");

   // an idle bus leaves both lines released and write protect raised
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !held.busy_res |->
         held.scl && held.sda_release && held.write_protect && !held.rd_valid)
      else $error("idle bus with active pins");

   // an empty result slot never stalls the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> req_tready)
      else $error("input stalled with empty result slot");

endmodule

// ===== bench/tb_i2c_eeprom_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_master: self-checking bench for the tick-driven EEPROM master
// Feeds bus tick words through the request stream and rebuilds every pin word
// in a behavioral copy of the bus sequencer, then compares the result stream
// field by field. Runs a directed plan first, then random transactions over
// a range of device bytes and phase lengths, with idling on both streams.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_master;
   import i2cm_pkg::*;

   localparam logic FN_READ  = 1'b0;
   localparam logic FN_WRITE = 1'b1;

   // fixed pin words that can be read straight off the bus protocol
   localparam result_type IDLE_WORD =
      result_type'({1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
   localparam result_type START_WR_WORD =
      result_type'({1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
   localparam result_type START_RD_WORD =
      result_type'({1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});

   typedef enum logic [1:0] {
      SDA_LOW = 2'd0, SDA_HIGH = 2'd1, SDA_RAND = 2'd2
   } sda_mode_type;
   typedef enum logic {ROW_IDLE = 1'b0, ROW_XFER = 1'b1} row_kind_type;

   // one line of the directed plan
   typedef struct {
      row_kind_type kind;
      bit           set_cfg;
      logic [7:0]   dev;
      logic [7:0]   pt;
      logic         func;
      logic [14:0]  addr;
      logic [15:0]  cnt;
      sda_mode_type sda;
      bit           pin;
      result_type   pin_val;
   } drow_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_addr;
   logic [7:0]  csr_wdata;

   // word in flight carries a typed-in expectation instead of the predicted one
   bit          word_pinned;
   result_type  pinned_word;

   result_type  pins_due[$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          ready_left = 0;

   // behavioral copy of the sequencer state and registers
   logic [7:0]  dev_reg;
   logic [7:0]  pt_reg;
   phase_type   bus_ph;
   logic [7:0]  ph_timer;
   logic [3:0]  bit_idx;
   logic [7:0]  shifter;
   logic [15:0] left;
   logic [14:0] addr_q;
   logic        wr_q;

   i2c_eeprom_master uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // sequencer copy
   // ---------------------------------------------------------------------
   function automatic void clear_sequencer();
      dev_reg  = DEVICE_BYTE_RESET;
      pt_reg   = PHASE_TICKS_RESET;
      bus_ph   = PH_IDLE;
      ph_timer = '0;
      bit_idx  = '0;
      shifter  = '0;
      left     = '0;
      addr_q   = '0;
      wr_q     = 1'b0;
   endfunction

   // enter a phase with a fresh bit counter and a byte to shift
   function automatic void enter(phase_type p, logic [7:0] b);
      bus_ph   = p;
      ph_timer = '0;
      bit_idx  = '0;
      shifter  = b;
   endfunction

   // advance one tick and return the pin word that follows it
   function automatic result_type next_pins(item_type t);
      logic [7:0] span;
      logic [4:0] code;
      phase_type  ph;
      result_type r;
      r = '0;
      // a zero phase length behaves like one tick
      span = (pt_reg == 8'd0) ? 8'd1 : pt_reg;
      if (bus_ph == PH_IDLE) begin
         if (t.req_valid) begin
            wr_q   = t.func;
            addr_q = t.mem_addr;
            left   = t.byte_count;
            enter(PH_S_HI, 8'h00);
         end
      end else if ({1'b0, ph_timer} + 9'd1 < {1'b0, span}) begin
         ph_timer = ph_timer + 8'd1;
      end else begin
         ph = bus_ph;
         ph_timer = '0;
         case (ph)
            PH_S_HI:   bus_ph = PH_S_FALL;
            PH_S_FALL: bus_ph = PH_S_LO;
            PH_S_LO:   enter(PH_DEV_LO, dev_reg);
            PH_R_HI:   bus_ph = PH_R_FALL;
            PH_R_FALL: bus_ph = PH_R_LO;
            // read device byte always carries the read bit
            PH_R_LO:   enter(PH_RD_LO, dev_reg | READ_BIT);
            PH_P_LO:   bus_ph = PH_P_HI;
            PH_P_HI:   bus_ph = PH_P_END;
            PH_P_END:  bus_ph = PH_IDLE;
            PH_DEV_LO, PH_AH_LO, PH_AL_LO, PH_RD_LO, PH_DAT_LO, PH_RX_LO:
               bus_ph = phase_type'(ph + 5'd1);
            PH_RX_HI: begin
               if (bit_idx < BITS_PER_BYTE) begin
                  shifter = {shifter[6:0], t.sda_in};
                  bit_idx = bit_idx + 4'd1;
                  if (bit_idx == BITS_PER_BYTE) begin
                     left        = left - 16'd1;
                     r.rd_valid  = 1'b1;
                     r.rd_byte   = shifter;
                     r.rd_last   = (left == 16'd0);
                  end
                  bus_ph = PH_RX_LO;
               end else if (left != 16'd0) begin
                  enter(PH_RX_LO, 8'h00);
               end else begin
                  enter(PH_P_LO, 8'h00);
               end
            end
            default: begin
               // high-clock phases of transmitted bytes
               if (bit_idx < BITS_PER_BYTE) begin
                  shifter = shifter << 1;
                  bit_idx = bit_idx + 4'd1;
                  bus_ph  = phase_type'(ph - 5'd1);
               end else if (ph == PH_DEV_HI) begin
                  enter(PH_AH_LO, {1'b0, addr_q[14:8] & ADDR_HI_MASK});
               end else if (ph == PH_AH_HI) begin
                  enter(PH_AL_LO, addr_q[7:0]);
               end else if (ph == PH_AL_HI && !wr_q) begin
                  enter(PH_R_HI, 8'h00);
               end else if (ph == PH_RD_HI) begin
                  enter((left != 16'd0) ? PH_RX_LO : PH_P_LO, 8'h00);
               end else if (ph == PH_AL_HI || ph == PH_DAT_HI) begin
                  if (left != 16'd0) begin
                     r.wr_byte_req = 1'b1;
                     left = left - 16'd1;
                     enter(PH_DAT_LO, t.wr_byte);
                  end else begin
                     enter(PH_P_LO, 8'h00);
                  end
               end else begin
                  enter(PH_P_LO, 8'h00);
               end
            end
         endcase
      end

      code = bus_ph;
      case (bus_ph)
         PH_IDLE, PH_S_HI, PH_R_HI, PH_P_END: begin
            r.scl = 1'b1;
            r.sda_release = 1'b1;
         end
         PH_S_FALL, PH_R_FALL, PH_P_HI: begin
            r.scl = 1'b1;
            r.sda_release = 1'b0;
         end
         PH_S_LO, PH_R_LO, PH_P_LO: begin
            r.scl = 1'b0;
            r.sda_release = 1'b0;
         end
         PH_RX_LO, PH_RX_HI: begin
            r.scl = (bus_ph == PH_RX_HI);
            // master acks every byte but the last
            r.sda_release = (bit_idx < BITS_PER_BYTE) ? 1'b1 : (left == 16'd0);
         end
         default: begin
            r.scl = code[0];
            r.sda_release = (bit_idx < BITS_PER_BYTE) ? shifter[7] : 1'b1;
         end
      endcase
      r.busy_res      = (bus_ph != PH_IDLE);
      r.write_protect = !(r.busy_res && wr_q);
      return r;
   endfunction

   task automatic check_pin(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // monitor: check result words, predict accepted tick words, track writes
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      result_type pred;
      item_type   t;
      if (reset) begin
         clear_sequencer();
         pins_due.delete();
      end else begin
         // check first so a word that outruns its tick shows up as unexpected
         if (rsp_tvalid && rsp_tready) begin
            if (pins_due.size() == 0) begin
               $error("result word with nothing expected: %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = pins_due.pop_front();
               check_pin("scl", 8'(want.scl), 8'(rsp_tdata[0]));
               check_pin("sda_release", 8'(want.sda_release), 8'(rsp_tdata[1]));
               check_pin("write_protect", 8'(want.write_protect), 8'(rsp_tdata[2]));
               check_pin("busy_res", 8'(want.busy_res), 8'(rsp_tdata[3]));
               check_pin("wr_byte_req", 8'(want.wr_byte_req), 8'(rsp_tdata[4]));
               check_pin("rd_byte", want.rd_byte, rsp_tdata[12:5]);
               check_pin("rd_valid", 8'(want.rd_valid), 8'(rsp_tdata[13]));
               check_pin("rd_last", 8'(want.rd_last), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            t.req_valid  = req_tdata[0];
            t.mem_addr   = req_tdata[15:1];
            t.byte_count = req_tdata[31:16];
            t.wr_byte    = req_tdata[39:32];
            t.sda_in     = req_tdata[40];
            t.func       = req_tuser;
            pred = next_pins(t);
            pins_due.push_back(word_pinned ? pinned_word : pred);
         end
         if (csr_we) begin
            if (csr_addr == CSR_DEVICE_BYTE) dev_reg = csr_wdata;
            else pt_reg = csr_wdata;
         end
      end
   end

   // receiver: ready stretches of random length, short stalls between them
   always @(negedge clock) begin
      if (ready_left == 0) begin
         if (rsp_tready) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 500)
                                                    : $urandom_range(0, 30);
         end
      end else begin
         ready_left--;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers; all of them start and end at a falling edge
   // ---------------------------------------------------------------------

   // tick word with random content; request fields only matter when idle
   function automatic item_type noise_tick(sda_mode_type m);
      item_type t;
      t.req_valid  = 1'($urandom_range(0, 1));
      t.func       = 1'($urandom_range(0, 1));
      t.mem_addr   = 15'($urandom);
      t.byte_count = 16'($urandom);
      t.wr_byte    = 8'($urandom);
      case (m)
         SDA_LOW:  t.sda_in = 1'b0;
         SDA_HIGH: t.sda_in = 1'b1;
         default:  t.sda_in = 1'($urandom_range(0, 1));
      endcase
      return t;
   endfunction

   // present one tick word, idling between bursts, and hold until taken
   task automatic send_tick(item_type t, bit pin, result_type pv);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;
      req_tdata   <= {7'd0, t.sda_in, t.wr_byte, t.byte_count, t.mem_addr, t.req_valid};
      req_tuser   <= t.func;
      word_pinned <= pin;
      pinned_word <= pv;
      req_tvalid  <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // issue one request, then keep ticking until the bus is idle again
   task automatic run_xfer(logic fn, logic [14:0] a, logic [15:0] n, sda_mode_type m,
                           bit pin, result_type pv);
      item_type t;
      t = noise_tick(m);
      t.req_valid  = 1'b1;
      t.func       = fn;
      t.mem_addr   = a;
      t.byte_count = n;
      send_tick(t, pin, pv);
      while (bus_ph != PH_IDLE) send_tick(noise_tick(m), 1'b0, '0);
   endtask

   // drop valid and wait out every pending result word
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pins_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_regs(logic [7:0] dev, logic [7:0] pt);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DEVICE_BYTE;
      csr_wdata <= dev;
      @(negedge clock);
      csr_addr  <= CSR_PHASE_TICKS;
      csr_wdata <= pt;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic drow_type mk_row(row_kind_type k, bit c, logic [7:0] d,
                                       logic [7:0] p, logic f, logic [14:0] a,
                                       logic [15:0] n, sda_mode_type m, bit pin,
                                       result_type pv);
      drow_type r;
      r.kind = k;  r.set_cfg = c; r.dev = d;   r.pt = p;  r.func = f;
      r.addr = a;  r.cnt = n;     r.sda = m;   r.pin = pin; r.pin_val = pv;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      drow_type     plan[10];
      item_type     t;
      sda_mode_type m;
      logic [7:0]   dev;
      logic [7:0]   pt;
      logic [15:0]  cnt;
      int           idle_n;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_we      = 1'b0;
      csr_addr    = CSR_DEVICE_BYTE;
      csr_wdata   = '0;
      word_pinned = 1'b0;
      pinned_word = '0;

      // idle word right out of reset, then a transfer at the reset settings
      plan[0] = mk_row(ROW_IDLE, 1'b0, 8'h00, 8'd0, FN_READ, 15'h0000, 16'd0,
                       SDA_RAND, 1'b1, IDLE_WORD);
      plan[1] = mk_row(ROW_XFER, 1'b0, 8'h00, 8'd0, FN_WRITE, 15'h1234, 16'd0,
                       SDA_RAND, 1'b1, START_WR_WORD);
      plan[2] = mk_row(ROW_XFER, 1'b1, 8'hA0, 8'd1, FN_READ, 15'h7FFF, 16'd2,
                       SDA_HIGH, 1'b1, START_RD_WORD);
      // zero byte count: no data bytes, both directions
      plan[3] = mk_row(ROW_XFER, 1'b1, 8'h00, 8'd1, FN_WRITE, 15'h0000, 16'd0,
                       SDA_LOW, 1'b1, START_WR_WORD);
      plan[4] = mk_row(ROW_XFER, 1'b0, 8'h00, 8'd0, FN_READ, 15'h0000, 16'd0,
                       SDA_LOW, 1'b1, START_RD_WORD);
      // zero phase length runs like one tick per phase
      plan[5] = mk_row(ROW_XFER, 1'b1, 8'hFE, 8'd0, FN_READ, 15'h7FFF, 16'd1,
                       SDA_LOW, 1'b0, '0);
      // device byte with bit zero already set
      plan[6] = mk_row(ROW_XFER, 1'b1, 8'hA1, 8'd1, FN_READ, 15'h2AAA, 16'd1,
                       SDA_RAND, 1'b0, '0);
      plan[7] = mk_row(ROW_XFER, 1'b0, 8'h00, 8'd0, FN_WRITE, 15'h5555, 16'd2,
                       SDA_RAND, 1'b0, '0);
      // longer phase
      plan[8] = mk_row(ROW_XFER, 1'b1, 8'h55, 8'd2, FN_WRITE, 15'h7F00, 16'd1,
                       SDA_RAND, 1'b0, '0);
      plan[9] = mk_row(ROW_IDLE, 1'b0, 8'h00, 8'd0, FN_READ, 15'h0000, 16'd0,
                       SDA_RAND, 1'b1, IDLE_WORD);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (plan[i]) begin
         if (plan[i].set_cfg) begin
            settle();
            set_regs(plan[i].dev, plan[i].pt);
         end
         if (plan[i].kind == ROW_IDLE) begin
            t = noise_tick(SDA_RAND);
            t.req_valid = 1'b0;
            send_tick(t, 1'b1, plan[i].pin_val);
         end else begin
            run_xfer(plan[i].func, plan[i].addr, plan[i].cnt, plan[i].sda,
                     plan[i].pin, plan[i].pin_val);
         end
      end

      // random transactions, two per setting, without settling between them
      for (int s = 0; s < 2; s++) begin
         settle();
         dev = 8'($urandom_range(0, 254));
         pt  = 8'($urandom_range(1, 2));
         set_regs(dev, pt);
         for (int k = 0; k < 2; k++) begin
            // zero to three idle words before each transfer
            idle_n = $urandom_range(0, 3);
            repeat (idle_n) begin
               t = noise_tick(SDA_RAND);
               t.req_valid = 1'b0;
               send_tick(t, 1'b0, '0);
            end
            cnt = 16'($urandom_range(0, 2));
            m = ($urandom_range(0, 5) == 0) ? sda_mode_type'($urandom_range(0, 1))
                                            : SDA_RAND;
            run_xfer(1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)), cnt, m,
                     1'b0, '0);
         end
      end

      // drain and let the pipeline go quiet
      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("tb_i2c_eeprom_master passed");
      else
         $display("tb_i2c_eeprom_master failed");
      $finish;
   end

   // watchdog
   initial begin
      #80_000_000;
      $display("tb_i2c_eeprom_master failed");
      $finish;
   end

endmodule

// ===== i2c_eeprom_master.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_seq.sv
hdl/i2cm_out_reg.sv
hdl/i2c_eeprom_master.sv
bench/tb_i2c_eeprom_master.sv
